### src/ssc_pkg.sv
// Shared types, codes and helpers for the substring search block.
// No dependencies; used by ssc_cell and substring_search_case_fold.
package ssc_pkg;

    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 6;
    localparam int POS_W      = 16;
    localparam int PLEN_CFG_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // transaction kind carried on s_tuser
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 2'd2;

    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_CASE_OFS = 8'h20;

    // broadcast to every cell of the compare row
    typedef struct packed {
        logic              shift;
        logic              fold_en;
        logic [CHAR_W-1:0] char_value;
        logic              pat_we;
        logic [IDX_W-1:0]  pat_idx;
    } cell_ctrl_t;

    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c, input logic en);
        if (en && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            return c + ASCII_CASE_OFS;
        end
        return c;
    endfunction

endpackage

### src/ssc_cell.sv
// One cell of the compare row: a pattern byte, a text byte and a compare.
// Depends on ssc_pkg.
module ssc_cell #(
    parameter int INDEX = 0
) (
    input  logic                      aclk,
    input  ssc_pkg::cell_ctrl_t       ctrl,
    input  logic                      insert,
    input  logic [ssc_pkg::CHAR_W-1:0] text_in,
    output logic [ssc_pkg::CHAR_W-1:0] text_out,
    output logic                      eq
);

    logic [ssc_pkg::CHAR_W-1:0] pattern_reg;
    logic [ssc_pkg::CHAR_W-1:0] text_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.pat_we && int'(ctrl.pat_idx) == INDEX) begin
            pattern_reg <= ctrl.char_value;
        end
        // new byte lands at the insert cell, the rest move one toward cell 0
        if (ctrl.shift) begin
            text_reg <= insert ? ctrl.char_value : text_in;
        end
    end

    assign text_out = text_reg;
    assign eq = ssc_pkg::fold(text_reg, ctrl.fold_en) == ssc_pkg::fold(pattern_reg, ctrl.fold_en);

endmodule

### src/substring_search_case_fold.sv
// Top level of the streaming substring search with optional ASCII case folding.
// Depends on ssc_pkg and ssc_cell.
//
// Pattern bytes are written as transactions with s_tuser = 0 (slot in s_tdata[13:8],
// byte in s_tdata[7:0]); text bytes follow with s_tuser = 1, the final one marked by
// s_tlast. The block reports the first start position at or after start_position where
// the pattern occurs, as one result transaction per text. A pattern or text byte can be
// taken while an earlier text byte is still in the compare stage, but after the last-marked
// text byte s_tready drops for one cycle while the result is formed; s_tready also stays low
// while a finished result waits on m_tready. The compare row that does the search is a
// chain of MAX_PATTERN cells, each holding one pattern byte and one text byte, all
// compared in one registered stage after the byte shifts in, then AND-reduced. Text
// bytes enter the chain at cell pattern_length-1, so cell i always holds the text byte
// that lines up with pattern byte i; pattern_length must therefore stay unchanged while
// a text is streaming (case_sensitive, start_position and pattern bytes may change).
// An empty pattern matches at start_position when that is at most the text length. Text past
// MAX_TEXT bytes is neither stored nor searched and raises the overflow flag.
module substring_search_case_fold #(
    parameter int MAX_PATTERN = 64,
    parameter int MAX_TEXT    = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_value[7:0], pattern_index[13:8], zero pad
    input  logic        s_tuser,   // cmd
    input  logic        s_tlast,   // last
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // found[0], match_position[16:1], overflow[17], zero pad
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int LW    = (LEN_W > ssc_pkg::PLEN_CFG_W) ? LEN_W : ssc_pkg::PLEN_CFG_W;
    localparam int CW    = $clog2(MAX_TEXT + 2);
    localparam int SW0   = (CW > LW) ? CW : LW;
    localparam int SW    = ((SW0 > ssc_pkg::POS_W) ? SW0 : ssc_pkg::POS_W) + 1;

    localparam int PW = ssc_pkg::POS_W;

    // configuration
    logic                              case_sens_reg, case_sens_next;
    logic [ssc_pkg::PLEN_CFG_W-1:0]    plen_reg, plen_next;
    logic [PW-1:0]                     start_reg, start_next;

    // search state
    logic [CW-1:0] count_reg, count_next;
    logic          match_seen_reg, match_seen_next;
    logic [PW-1:0] first_match_reg, first_match_next;

    // compare stage: one entry for the text byte accepted last cycle
    logic          chk_pend_reg, chk_pend_next;
    logic          chk_last_reg, chk_last_next;
    logic          chk_store_reg, chk_store_next;
    logic [CW-1:0] chk_pos_reg, chk_pos_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic          out_found_reg, out_found_next;
    logic [PW-1:0] out_pos_reg, out_pos_next;
    logic          out_ovf_reg, out_ovf_next;

    logic s_accept, text_acc, pat_acc, room, fin, ovf, hit, match_now;
    logic [LW-1:0] len;
    logic [SW-1:0] end_p1, len_x, start_cand, searched;

    ssc_pkg::cell_ctrl_t cell_ctrl;
    logic [MAX_PATTERN-1:0] insert_vec, use_vec, eq_vec;
    logic [ssc_pkg::CHAR_W-1:0] text_chain [0:MAX_PATTERN];

    // a last byte in the compare stage blocks input for one cycle
    assign fin      = chk_pend_reg && chk_last_reg;
    assign s_tready = !fin && (!out_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign text_acc = s_accept && (s_tuser == ssc_pkg::CMD_TEXT);
    assign pat_acc  = s_accept && (s_tuser == ssc_pkg::CMD_PATTERN);
    assign room     = count_reg < CW'(MAX_TEXT);

    // pattern length saturates at the row length
    assign len = (LW'(plen_reg) > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(plen_reg);

    assign cell_ctrl.shift      = text_acc && room;
    assign cell_ctrl.fold_en    = !case_sens_reg;
    assign cell_ctrl.char_value = s_tdata[7:0];
    assign cell_ctrl.pat_we     = pat_acc;
    assign cell_ctrl.pat_idx    = s_tdata[13:8];

    assign text_chain[MAX_PATTERN] = s_tdata[7:0];

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
        assign insert_vec[i] = (len == LW'(i + 1));
        assign use_vec[i]    = (LW'(i) < len);
        ssc_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl),
            .insert  (insert_vec[i]),
            .text_in (text_chain[i + 1]),
            .text_out(text_chain[i]),
            .eq      (eq_vec[i])
        );
    end

    // cells past the pattern length do not take part
    assign hit = &(eq_vec | ~use_vec);

    // candidate start for a match ending at the byte in the compare stage
    assign end_p1     = SW'(chk_pos_reg) + SW'(1);
    assign len_x      = SW'(len);
    assign start_cand = end_p1 - len_x;
    assign match_now  = chk_pend_reg && chk_store_reg && !match_seen_reg && (len != '0)
                        && (end_p1 >= len_x) && (start_cand >= SW'(start_reg)) && hit;

    assign ovf      = count_reg > CW'(MAX_TEXT);
    assign searched = ovf ? SW'(MAX_TEXT) : SW'(count_reg);

    always_comb begin
        case_sens_next   = case_sens_reg;
        plen_next        = plen_reg;
        start_next       = start_reg;
        count_next       = count_reg;
        match_seen_next  = match_seen_reg;
        first_match_next = first_match_reg;
        chk_pend_next    = text_acc;
        chk_last_next    = s_tlast;
        chk_store_next   = chk_store_reg;
        chk_pos_next     = chk_pos_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_found_next   = out_found_reg;
        out_pos_next     = out_pos_reg;
        out_ovf_next     = out_ovf_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                ssc_pkg::REG_CASE_SENSITIVE: case_sens_next = cfg_wdata[0];
                ssc_pkg::REG_PATTERN_LENGTH: plen_next = cfg_wdata[ssc_pkg::PLEN_CFG_W-1:0];
                ssc_pkg::REG_START_POSITION: start_next = cfg_wdata[PW-1:0];
                default: ;
            endcase
        end

        if (text_acc) begin
            chk_pos_next   = count_reg;
            chk_store_next = room;
            if (room) begin
                count_next = count_reg + CW'(1);
            end else begin
                count_next = CW'(MAX_TEXT + 1);
            end
        end

        if (match_now) begin
            match_seen_next  = 1'b1;
            first_match_next = start_cand[PW-1:0];
        end

        // last byte: form the result and clear the search for the next text
        if (fin) begin
            out_valid_next = 1'b1;
            out_ovf_next   = ovf;
            if (len == '0) begin
                out_found_next = SW'(start_reg) <= searched;
                out_pos_next   = (SW'(start_reg) <= searched) ? start_reg : '0;
            end else begin
                out_found_next = match_seen_reg || match_now;
                priority if (match_seen_reg) begin
                    out_pos_next = first_match_reg;
                end else if (match_now) begin
                    out_pos_next = start_cand[PW-1:0];
                end else begin
                    out_pos_next = '0;
                end
            end
            count_next       = '0;
            match_seen_next  = 1'b0;
            first_match_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            case_sens_reg   <= 1'b1;
            plen_reg        <= '0;
            start_reg       <= '0;
            count_reg       <= '0;
            match_seen_reg  <= 1'b0;
            first_match_reg <= '0;
            chk_pend_reg    <= 1'b0;
            chk_last_reg    <= 1'b0;
            chk_store_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            case_sens_reg   <= case_sens_next;
            plen_reg        <= plen_next;
            start_reg       <= start_next;
            count_reg       <= count_next;
            match_seen_reg  <= match_seen_next;
            first_match_reg <= first_match_next;
            chk_pend_reg    <= chk_pend_next;
            chk_last_reg    <= chk_last_next;
            chk_store_reg   <= chk_store_next;
            out_valid_reg   <= out_valid_next;
        end
        chk_pos_reg   <= chk_pos_next;
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_ovf_reg, out_pos_reg, out_found_reg};

endmodule

### src/ssc_checker.sv
// Port-level checks for substring_search_case_fold, attached by bind.
// Depends on nothing but the top level's port list.
module ssc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic last_acc;
    assign last_acc = s_tvalid && s_tready && s_tuser && s_tlast;

    // result register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // after the last text byte, s_tready drops while it is in the compare stage, then the result turns valid
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        last_acc |=> !s_tready ##1 m_tvalid)
        else $error("no result after last text byte");

    // a result appears only after a last text byte
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(last_acc, 2))
        else $error("result without a last text byte");

    // not found reports position zero
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
        else $error("nonzero position without a match");

endmodule

bind substring_search_case_fold ssc_checker u_ssc_checker (.*);

### tb/substring_search_case_fold_tb.sv
// Self-checking testbench for substring_search_case_fold: directed table, one
// overflow-length text, then random pattern/text phases scored by a predictor.
// Depends on ssc_pkg and the block RTL only.
module substring_search_case_fold_tb;
    import ssc_pkg::*;

    localparam int PAT_SLOTS     = 64;       // MAX_PATTERN of the instance
    localparam int TEXT_MAX      = 65536;    // MAX_TEXT of the instance
    localparam int SETTLE_CYCLES = 8;        // drain time before a register write
    localparam int RAND_ITEMS    = 1850;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int REPORT_CAP    = 200;

    // index with no register behind it; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
        logic             ovf;
    } search_res_t;

    // one row of the directed table: a register write or an input transaction
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  cmd;
        logic [CHAR_W-1:0]     ch;
        logic [IDX_W-1:0]      idx;
        logic                  last;
        bit                    has_gold;  // result typed in by hand
        search_res_t           gold;
    } row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;  // char_value[7:0], pattern_index[13:8], zero pad
    logic                  s_tuser   = 1'b0; // cmd
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;         // found[0], match_position[16:1], overflow[17]

    // hand-typed result riding along with the current input transaction
    bit          gold_on  = 1'b0;
    search_res_t gold_res = '0;

    int src_idle_pct = 8;
    int snk_idle_pct = 8;
    int mismatches   = 0;
    int cycles       = 0;

    // ---------------------------------------------------------------
    // Predictor state: pattern slots, sliding text window, search status
    // and a shadow of the three registers.
    // ---------------------------------------------------------------
    logic [CHAR_W-1:0] pat_mem [PAT_SLOTS] = '{default: '0};
    logic [CHAR_W-1:0] win     [PAT_SLOTS] = '{default: '0};
    int                txt_cnt  = 0;
    bit                hit      = 1'b0;
    logic [POS_W-1:0]  hit_pos  = '0;
    bit                cfg_case = 1'b1;
    int                cfg_plen = 0;
    int                cfg_start = 0;

    search_res_t pending_results[$];

    substring_search_case_fold u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // result side backpressure, changed on the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ASCII lower-casing, only while case sensitivity is off
    function automatic logic [CHAR_W-1:0] fold_letter(input logic [CHAR_W-1:0] c);
        if (!cfg_case && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            return c + ASCII_CASE_OFS;
        end
        return c;
    endfunction

    // Advance the search by one accepted transaction; produced is set when a
    // text byte carries the last mark.
    task automatic predict_byte(input logic cmd, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx, input logic last,
                                output bit produced, output search_res_t res);
        int  len;
        int  pos;
        int  s;
        int  searched;
        bit  same;
        bit  ovf;
        produced = 1'b0;
        res      = '0;
        if (cmd == CMD_PATTERN) begin
            pat_mem[idx] = ch;   // last mark means nothing here
            return;
        end
        len = (cfg_plen > PAT_SLOTS) ? PAT_SLOTS : cfg_plen;
        if (txt_cnt < TEXT_MAX) begin
            pos = txt_cnt;
            win[pos % PAT_SLOTS] = ch;
            txt_cnt = pos + 1;
            // does the pattern end on this byte, starting late enough?
            if (!hit && len != 0 && pos + 1 >= len) begin
                s = pos + 1 - len;
                if (s >= cfg_start) begin
                    same = 1'b1;
                    for (int i = 0; i < len; i++) begin
                        if (fold_letter(win[(s + i) % PAT_SLOTS]) != fold_letter(pat_mem[i])) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        hit     = 1'b1;
                        hit_pos = s[POS_W-1:0];
                    end
                end
            end
        end else begin
            // bytes past the text limit only mark overflow
            txt_cnt = TEXT_MAX + 1;
        end
        if (!last) begin
            return;
        end
        ovf      = (txt_cnt > TEXT_MAX);
        searched = ovf ? TEXT_MAX : txt_cnt;
        if (len == 0) begin
            // empty pattern hits at start_position if that is at most the text length
            res.found = (cfg_start <= searched);
            res.pos   = res.found ? cfg_start[POS_W-1:0] : '0;
        end else begin
            res.found = hit;
            res.pos   = hit ? hit_pos : '0;
        end
        res.ovf  = ovf;
        produced = 1'b1;
        for (int i = 0; i < PAT_SLOTS; i++) begin
            win[i] = '0;
        end
        txt_cnt = 0;
        hit     = 1'b0;
        hit_pos = '0;
    endtask

    // ---------------------------------------------------------------
    // Monitor: register shadow, input transactions into the predictor,
    // result transactions against the oldest expectation.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        bit          produced;
        search_res_t want;
        search_res_t got;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CASE_SENSITIVE: cfg_case  = cfg_wdata[0];
                    REG_PATTERN_LENGTH: cfg_plen  = cfg_wdata[PLEN_CFG_W-1:0];
                    REG_START_POSITION: cfg_start = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_byte(s_tuser, s_tdata[CHAR_W-1:0], s_tdata[CHAR_W+IDX_W-1:CHAR_W],
                             s_tlast, produced, want);
                if (produced) begin
                    pending_results.push_back(gold_on ? gold_res : want);
                end
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[0], m_tdata[16:1], m_tdata[17]};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches < REPORT_CAP) begin
                        $display("%0t: result transaction with none expected: found=%0b pos=%0d ovf=%0b",
                                 $time, got.found, got.pos, got.ovf);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found) begin
                        mismatches++;
                        if (mismatches < REPORT_CAP)
                            $display("%0t: found expected %0b actual %0b",
                                     $time, want.found, got.found);
                    end
                    if (got.pos !== want.pos) begin
                        mismatches++;
                        if (mismatches < REPORT_CAP)
                            $display("%0t: match_position expected %0d actual %0d",
                                     $time, want.pos, got.pos);
                    end
                    if (got.ovf !== want.ovf) begin
                        mismatches++;
                        if (mismatches < REPORT_CAP)
                            $display("%0t: overflow expected %0b actual %0b",
                                     $time, want.ovf, got.ovf);
                    end
                end
            end
        end
    end

    // One input transaction: optional random gap, then hold until accepted.
    task automatic send_byte(input logic cmd, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx, input logic last,
                             input bit gold = 1'b0, input search_res_t g = '0);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, idx, ch};
        s_tlast  <= last;
        gold_on  <= gold;
        gold_res <= g;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait for every expected result, then let the pipeline drain.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly a two-letter alphabet in both cases so that matches happen
    function automatic logic [CHAR_W-1:0] rand_char();
        case ($urandom_range(0, 9))
            0, 1:    return "a";
            2, 3:    return "b";
            4:       return "A";
            5:       return "B";
            6:       return "c";
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic row_t text_row(input logic [CHAR_W-1:0] ch, input logic last,
                                      input logic [IDX_W-1:0] idx = '0,
                                      input bit gold = 1'b0, input search_res_t g = '0);
        row_t r;
        r = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, cmd: CMD_TEXT, ch: ch, idx: idx,
              last: last, has_gold: gold, gold: g};
        return r;
    endfunction

    function automatic row_t pat_row(input logic [CHAR_W-1:0] ch, input logic [IDX_W-1:0] idx,
                                     input logic last);
        row_t r;
        r = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, cmd: CMD_PATTERN, ch: ch, idx: idx,
              last: last, has_gold: 1'b0, gold: '0};
        return r;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        row_t r;
        r = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, cmd: CMD_TEXT, ch: '0, idx: '0,
              last: 1'b0, has_gold: 1'b0, gold: '0};
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        row_t              rows[$];
        logic [CHAR_W-1:0] txt[$];
        logic [CHAR_W-1:0] c;
        int                n_rand;
        int                r;
        int                slots;
        int                plen_sel;
        int                pre;
        int                post;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table. Hand-typed results only where they are obvious.
        // Empty pattern right after reset: hit at position 0.
        rows.push_back(text_row("a", 1'b1, '0, 1'b1, '{1'b1, 16'd0, 1'b0}));
        // extreme byte values; the slot field of a text byte is don't-care
        rows.push_back(text_row(8'h00, 1'b0, 6'd63));
        rows.push_back(text_row(8'hFF, 1'b1, '0, 1'b1, '{1'b1, 16'd0, 1'b0}));
        // last mark on a pattern write gives no result
        rows.push_back(pat_row("A", 6'd0, 1'b1));
        rows.push_back(pat_row("b", 6'd1, 1'b0));
        rows.push_back(pat_row(8'hFF, 6'd63, 1'b0));
        rows.push_back(reg_row(REG_PATTERN_LENGTH, 16'd2));
        // exact compare: "Ab" found inside "aAb"
        rows.push_back(text_row("a", 1'b0));
        rows.push_back(text_row("A", 1'b0));
        rows.push_back(text_row("b", 1'b1, '0, 1'b1, '{1'b1, 16'd1, 1'b0}));
        // folded compare: "aB" matches "Ab"
        rows.push_back(reg_row(REG_CASE_SENSITIVE, 16'd0));
        rows.push_back(text_row("a", 1'b0));
        rows.push_back(text_row("B", 1'b1, '0, 1'b1, '{1'b1, 16'd0, 1'b0}));
        // match before start_position does not count
        rows.push_back(reg_row(REG_START_POSITION, 16'd1));
        rows.push_back(text_row("a", 1'b0));
        rows.push_back(text_row("b", 1'b1, '0, 1'b1, '{1'b0, 16'd0, 1'b0}));
        rows.push_back(text_row("x", 1'b0));
        rows.push_back(text_row("a", 1'b0));
        rows.push_back(text_row("b", 1'b1));
        // empty pattern, start past the end of the text
        rows.push_back(reg_row(REG_START_POSITION, 16'hFFFF));
        rows.push_back(reg_row(REG_PATTERN_LENGTH, 16'd0));
        rows.push_back(text_row("z", 1'b1, '0, 1'b1, '{1'b0, 16'd0, 1'b0}));
        // empty pattern, start exactly at the text length
        rows.push_back(reg_row(REG_START_POSITION, 16'd2));
        rows.push_back(text_row("p", 1'b0));
        rows.push_back(text_row("q", 1'b1, '0, 1'b1, '{1'b1, 16'd2, 1'b0}));
        // fold boundaries: '@' and '[' sit just outside A..Z
        rows.push_back(reg_row(REG_PATTERN_LENGTH, 16'd1));
        rows.push_back(reg_row(REG_START_POSITION, 16'd0));
        rows.push_back(text_row("@", 1'b0));
        rows.push_back(text_row("[", 1'b0));
        rows.push_back(text_row("a", 1'b1, '0, 1'b1, '{1'b1, 16'd2, 1'b0}));

        foreach (rows[i]) begin
            if (rows[i].is_reg) begin
                settle();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end else begin
                send_byte(rows[i].cmd, rows[i].ch, rows[i].idx, rows[i].last,
                          rows[i].has_gold, rows[i].gold);
            end
        end

        // Overflow: text runs past the limit. A copy of the pattern that starts just under the
        // limit and ends past it is never searched, so no match is found.
        settle();
        write_reg(REG_CASE_SENSITIVE, 16'd1);
        write_reg(REG_PATTERN_LENGTH, 16'd3);
        write_reg(REG_START_POSITION, 16'hFFF0);
        send_byte(CMD_PATTERN, "x", 6'd0, 1'b0);
        send_byte(CMD_PATTERN, "y", 6'd1, 1'b0);
        send_byte(CMD_PATTERN, "z", 6'd2, 1'b0);
        for (int p = 0; p < TEXT_MAX + 4; p++) begin
            case (p % 3)
                0:       c = "x";
                1:       c = "y";
                default: c = "z";
            endcase
            if (p < TEXT_MAX - 3 && p != 100 && p != 101 && p != 102) begin
                c = "q";
            end
            send_byte(CMD_TEXT, c, 6'($urandom), p == TEXT_MAX + 3);
        end

        // Random phases: registers while idle, refill the active pattern
        // slots, then one text with the pattern often planted in it.
        n_rand = 0;
        while (n_rand < RAND_ITEMS) begin
            // long stretch with no idling on either side
            src_idle_pct = (n_rand > 700 && n_rand < 1000) ? 0 : 8;
            snk_idle_pct = src_idle_pct;
            settle();

            if ($urandom_range(0, 1)) begin
                write_reg(REG_CASE_SENSITIVE, 16'($urandom));
            end
            if ($urandom_range(0, 3) != 0) begin
                r = $urandom_range(0, 99);
                if (r < 12)      plen_sel = 0;
                else if (r < 22) plen_sel = PAT_SLOTS;
                else if (r < 27) plen_sel = $urandom_range(PAT_SLOTS + 1, 127);
                else if (r < 35) plen_sel = $urandom_range(9, PAT_SLOTS - 1);
                else             plen_sel = $urandom_range(1, 8);
                write_reg(REG_PATTERN_LENGTH, {9'($urandom), 7'(plen_sel)});
            end
            if ($urandom_range(0, 1)) begin
                r = $urandom_range(0, 99);
                if (r < 60)      write_reg(REG_START_POSITION, 16'd0);
                else if (r < 85) write_reg(REG_START_POSITION, 16'($urandom_range(0, 8)));
                else if (r < 90) write_reg(REG_START_POSITION, 16'hFFFF);
                else             write_reg(REG_START_POSITION, 16'($urandom));
            end
            if ($urandom_range(0, 19) == 0) begin
                write_reg(REG_SPARE, 16'($urandom));
            end

            // every active slot gets written before any text compares it
            slots = (cfg_plen > PAT_SLOTS) ? PAT_SLOTS : cfg_plen;
            if ($urandom_range(0, 1) || slots > 0) begin
                for (int k = 0; k < slots; k++) begin
                    send_byte(CMD_PATTERN, rand_char(), 6'(k), 1'($urandom));
                    n_rand++;
                end
            end

            txt.delete();
            pre = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20) : $urandom_range(21, 150);
            repeat (pre) txt.push_back(rand_char());
            if (slots != 0 && $urandom_range(0, 99) < 60) begin
                for (int k = 0; k < slots; k++) begin
                    c = pat_mem[k];
                    if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 3) == 0) begin
                        c = c ^ ASCII_CASE_OFS;
                    end
                    txt.push_back(c);
                end
            end
            post = $urandom_range(0, 6);
            repeat (post) txt.push_back(rand_char());

            foreach (txt[k]) begin
                // stray pattern writes in the middle of a text
                if ($urandom_range(0, 99) < 3) begin
                    send_byte(CMD_PATTERN, 8'($urandom), 6'($urandom), 1'($urandom));
                    n_rand++;
                end
                send_byte(CMD_TEXT, txt[k], 6'($urandom), k == txt.size() - 1);
                n_rand++;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
